// ===== rtl/voxlod_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel detail pyramid store package
// Shared types, constants and addressing helpers for the pyramid store.
// ----------------------------------------------------------------------------
package voxlod_pkg;

    localparam int EDGE       = 32;
    localparam int EDGE_LOG2  = $clog2(EDGE);
    localparam int MAX_LEVELS = 6;
    localparam int LEVEL_W    = 3;
    localparam int COORD_W    = 5;
    localparam int EDGE_W     = $clog2(EDGE + 1);
    localparam int TYPE_W     = 16;
    localparam int DATA_W     = 8;
    localparam int WORD_W     = TYPE_W + DATA_W;

    function automatic int cube_of(input int e);
        return e * e * e;
    endfunction

    function automatic int store_depth_calc();
        int sum;
        sum = 0;
        for (int l = 0; l < 8; l++) begin
            sum += cube_of(EDGE >> l);
        end
        return sum;
    endfunction

    localparam int STORE_DEPTH = store_depth_calc();
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_PROP  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RWAIT,
        ST_GREQ,
        ST_GCHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic [TYPE_W-1:0]  type_in;
        logic [DATA_W-1:0]  data_in;
    } in_item_t;

    typedef struct packed {
        logic [TYPE_W-1:0] type_out;
        logic [DATA_W-1:0] data_out;
        logic              status;
    } out_item_t;

    function automatic logic [EDGE_W-1:0] level_edge(input logic [LEVEL_W:0] lv);
        return EDGE_W'(EDGE >> lv);
    endfunction

    function automatic logic [ADDR_W-1:0] level_base(input logic [LEVEL_W-1:0] lv);
        logic [ADDR_W-1:0] sum;
        sum = '0;
        for (int l = 0; l < 8; l++) begin
            if (l < int'(lv)) begin
                sum = sum + ADDR_W'(cube_of(EDGE >> l));
            end
        end
        return sum;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [LEVEL_W-1:0] lv,
                                                    input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
        logic [LEVEL_W:0]  sh;
        logic [ADDR_W-1:0] off;
        sh  = (LEVEL_W + 1)'(EDGE_LOG2) - {1'b0, lv};
        off = (ADDR_W'(z) << (2 * sh)) | (ADDR_W'(y) << sh) | ADDR_W'(x);
        return level_base(lv) + off;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/voxel_lod_pyramid_store_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel detail pyramid store
// Cell read, cell write and upward propagation over a packed pyramid memory.
// ----------------------------------------------------------------------------
// After reset the block zeroes its single-port-style store one word per cycle
// and accepts no item until that pass is over. A read issues its memory read
// at acceptance, takes the word in ST_RWAIT and returns it from ST_DONE; a
// write stores its word at acceptance and goes straight to ST_DONE. A
// propagate is limited by the one memory read port: each level starts in
// ST_GREQ, then examines group members one at a time (at most eight) in ST_GCHK.
// Items are handled one at a time; a finished result sits in the output
// register while the next item is accepted.
module voxel_lod_pyramid_store_core (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_wr_en,
    input  wire [2:0]             cfg_wr_data,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  voxlod_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  wire                   m_ready,
    output voxlod_pkg::out_item_t m_item
);

    localparam int AW = voxlod_pkg::ADDR_W;
    localparam int CW = voxlod_pkg::COORD_W;
    localparam int LW = voxlod_pkg::LEVEL_W;
    localparam int EW = voxlod_pkg::EDGE_W;
    localparam int TW = voxlod_pkg::TYPE_W;
    localparam int DW = voxlod_pkg::DATA_W;

    logic [voxlod_pkg::WORD_W-1:0] mem [voxlod_pkg::STORE_DEPTH];
    logic [voxlod_pkg::WORD_W-1:0] mem_rdata_reg;
    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [voxlod_pkg::WORD_W-1:0] mem_wdata;

    voxlod_pkg::state_t state_reg, state_next;
    logic [2:0]      levels_reg;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [1:0]      op_reg, op_next;
    logic [LW-1:0]   lv_reg, lv_next;
    logic [CW-1:0]   x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [TW-1:0]   t_reg, t_next, pt_reg, pt_next;
    logic [DW-1:0]   d_reg, d_next, pd_reg, pd_next;
    logic            st_reg, st_next;
    logic [2:0]      idx_reg, idx_next;
    logic            m_valid_reg, m_valid_next;
    voxlod_pkg::out_item_t out_reg, out_next;

    logic [LW:0]     top;
    logic [EW-1:0]   in_e, cur_e, par_e;
    logic            reject;
    logic [2:0]      nidx;
    logic [CW-1:0]   cx, cy, cz, nx, ny, nz, px, py, pz;
    logic            inr, found;
    logic [TW-1:0]   ct, sel_t;
    logic [DW-1:0]   cd, sel_d;

    always_comb begin
        if (levels_reg == 3'd0) begin
            top = (LW + 1)'(1);
        end else if (int'(levels_reg) > voxlod_pkg::MAX_LEVELS) begin
            top = (LW + 1)'(voxlod_pkg::MAX_LEVELS);
        end else begin
            top = {1'b0, levels_reg};
        end
    end

    assign in_e  = voxlod_pkg::level_edge({1'b0, s_item.level});
    assign cur_e = voxlod_pkg::level_edge({1'b0, lv_reg});
    assign par_e = voxlod_pkg::level_edge({1'b0, lv_reg} + 1'b1);
    assign reject = (s_item.op != voxlod_pkg::OP_READ && s_item.op != voxlod_pkg::OP_WRITE
                     && s_item.op != voxlod_pkg::OP_PROP)
                    || ({1'b0, s_item.level} >= top) || (in_e == '0)
                    || (EW'(s_item.cell_x) >= in_e) || (EW'(s_item.cell_y) >= in_e)
                    || (EW'(s_item.cell_z) >= in_e);

    assign cx = {x_reg[CW-1:1], idx_reg[0]};
    assign cy = {y_reg[CW-1:1], idx_reg[1]};
    assign cz = {z_reg[CW-1:1], idx_reg[2]};
    assign nidx = idx_reg + 3'd1;
    assign nx = {x_reg[CW-1:1], nidx[0]};
    assign ny = {y_reg[CW-1:1], nidx[1]};
    assign nz = {z_reg[CW-1:1], nidx[2]};
    assign px = x_reg >> 1;
    assign py = y_reg >> 1;
    assign pz = z_reg >> 1;
    assign inr = (EW'(cx) < cur_e) && (EW'(cy) < cur_e) && (EW'(cz) < cur_e);
    assign ct = inr ? mem_rdata_reg[voxlod_pkg::WORD_W-1:DW] : '0;
    assign cd = inr ? mem_rdata_reg[DW-1:0] : '0;
    assign found = (ct != '0) || (idx_reg == 3'd7);
    assign sel_t = (ct != '0 || idx_reg == 3'd0) ? ct : pt_reg;
    assign sel_d = (ct != '0 || idx_reg == 3'd0) ? cd : pd_reg;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        lv_next      = lv_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        t_next       = t_reg;
        d_next       = d_reg;
        pt_next      = pt_reg;
        pd_next      = pd_reg;
        st_next      = st_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        s_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = clr_reg;
        mem_raddr    = voxlod_pkg::cell_addr(lv_reg, x_reg, y_reg, z_reg);
        mem_wdata    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            voxlod_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (int'(clr_reg) == voxlod_pkg::STORE_DEPTH - 1) begin
                    state_next = voxlod_pkg::ST_IDLE;
                end
            end
            voxlod_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next = s_item.op;
                    lv_next = s_item.level;
                    x_next  = s_item.cell_x;
                    y_next  = s_item.cell_y;
                    z_next  = s_item.cell_z;
                    mem_raddr = voxlod_pkg::cell_addr(s_item.level, s_item.cell_x,
                                                      s_item.cell_y, s_item.cell_z);
                    if (reject) begin
                        st_next    = 1'b1;
                        t_next     = '0;
                        d_next     = '0;
                        state_next = voxlod_pkg::ST_DONE;
                    end else if (s_item.op == voxlod_pkg::OP_WRITE) begin
                        st_next    = 1'b0;
                        mem_we     = 1'b1;
                        mem_waddr  = mem_raddr;
                        mem_wdata  = {s_item.type_in, s_item.data_in};
                        t_next     = s_item.type_in;
                        d_next     = s_item.data_in;
                        state_next = voxlod_pkg::ST_DONE;
                    end else begin
                        st_next    = 1'b0;
                        mem_re     = 1'b1;
                        state_next = voxlod_pkg::ST_RWAIT;
                    end
                end
            end
            voxlod_pkg::ST_RWAIT: begin
                t_next = mem_rdata_reg[voxlod_pkg::WORD_W-1:DW];
                d_next = mem_rdata_reg[DW-1:0];
                if (op_reg == voxlod_pkg::OP_READ || ({1'b0, lv_reg} + 1'b1) >= top) begin
                    state_next = voxlod_pkg::ST_DONE;
                end else begin
                    state_next = voxlod_pkg::ST_GREQ;
                end
            end
            voxlod_pkg::ST_GREQ: begin
                mem_re     = 1'b1;
                mem_raddr  = voxlod_pkg::cell_addr(lv_reg, {x_reg[CW-1:1], 1'b0},
                                                   {y_reg[CW-1:1], 1'b0},
                                                   {z_reg[CW-1:1], 1'b0});
                idx_next   = 3'd0;
                state_next = voxlod_pkg::ST_GCHK;
            end
            voxlod_pkg::ST_GCHK: begin
                pt_next = sel_t;
                pd_next = sel_d;
                if (!found) begin
                    mem_re    = 1'b1;
                    mem_raddr = voxlod_pkg::cell_addr(lv_reg, nx, ny, nz);
                    idx_next  = nidx;
                end else if (par_e == '0 || EW'(px) >= par_e || EW'(py) >= par_e
                             || EW'(pz) >= par_e) begin
                    state_next = voxlod_pkg::ST_DONE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = voxlod_pkg::cell_addr(lv_reg + 1'b1, px, py, pz);
                    mem_wdata = {sel_t, sel_d};
                    t_next    = sel_t;
                    d_next    = sel_d;
                    lv_next   = lv_reg + 1'b1;
                    x_next    = px;
                    y_next    = py;
                    z_next    = pz;
                    if (({1'b0, lv_reg} + (LW + 1)'(2)) < top) begin
                        state_next = voxlod_pkg::ST_GREQ;
                    end else begin
                        state_next = voxlod_pkg::ST_DONE;
                    end
                end
            end
            voxlod_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    out_next.type_out = t_reg;
                    out_next.data_out = d_reg;
                    out_next.status   = st_reg;
                    state_next        = voxlod_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = voxlod_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= voxlod_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            levels_reg  <= 3'd6;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                levels_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        lv_reg  <= lv_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        t_reg   <= t_next;
        d_reg   <= d_next;
        pt_reg  <= pt_next;
        pd_reg  <= pd_next;
        st_reg  <= st_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != voxlod_pkg::ST_IDLE))
        else $error("item accepted but control stayed idle");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == voxlod_pkg::ST_CLEAR) |-> !s_ready)
        else $error("input ready during clearing pass");

    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of one entry in one cycle");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status) |-> (m_item.type_out == '0 && m_item.data_out == '0))
        else $error("rejected item carries nonzero payload");

endmodule
`default_nettype wire
